// ===== src/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and codes for the positional array table unit.
// ----------------------------------------------------------------------------
package pat_pkg;

  // Operation codes carried on the command channel.
  localparam logic [1:0] OP_DISPLAY = 2'd0;
  localparam logic [1:0] OP_SEARCH  = 2'd1;
  localparam logic [1:0] OP_INSERT  = 2'd2;
  localparam logic [1:0] OP_DELETE  = 2'd3;

  // Status codes carried on the response channel.
  localparam logic [2:0] ST_ELEMENT  = 3'd0;
  localparam logic [2:0] ST_FOUND    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_INSERTED = 3'd3;
  localparam logic [2:0] ST_DELETED  = 3'd4;
  localparam logic [2:0] ST_INVALID  = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;
  localparam logic [2:0] ST_EMPTY    = 3'd7;

  // Command item.
  typedef struct packed {
    logic [1:0]         operation;
    logic [6:0]         position;
    logic signed [31:0] value;
  } cmd_t;

  // Response item.
  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         index;
    logic signed [31:0] data;
    logic [6:0]         entry_count;
    logic               last;
  } rsp_t;

  // Broadcast control for the row of storage cells. A rotation is a shift
  // down from position zero, with the last cell taking the first cell's entry.
  typedef struct packed {
    logic               shift_up;
    logic               shift_down;
    logic [6:0]         pos;
    logic signed [31:0] value;
  } cell_cmd_t;

endpackage

// ===== src/pat_cell.sv =====
// ----------------------------------------------------------------------------
// pat_cell
// One storage cell of the table row. It holds one entry and takes its
// neighbor's entry when the row shifts past its own index.
// ----------------------------------------------------------------------------
module pat_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  pat_pkg::cell_cmd_t        cell_cmd,
  input  logic signed [31:0]        left,
  input  logic signed [31:0]        right,
  output logic signed [31:0]        data
);
  import pat_pkg::*;

  localparam logic [6:0] MY_IDX = 7'(IDX);

  // Insert moves entries above the position up; delete and rotate move
  // entries at or above the position down.
  always_ff @(posedge clk) begin
    if (cell_cmd.shift_up && (MY_IDX > cell_cmd.pos)) begin
      data <= left;
    end else if (cell_cmd.shift_up && (MY_IDX == cell_cmd.pos)) begin
      data <= cell_cmd.value;
    end else if (cell_cmd.shift_down && (MY_IDX >= cell_cmd.pos)) begin
      data <= right;
    end
  end

endmodule

// ===== src/pat_ctrl.sv =====
// ----------------------------------------------------------------------------
// pat_ctrl
// Sequencer for the table: decodes commands, keeps the entry count, drives
// the cell row and holds the response register.
// ----------------------------------------------------------------------------
module pat_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  pat_pkg::cmd_t        cmd,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output pat_pkg::rsp_t        rsp,
  input  logic signed [31:0]   head,
  output pat_pkg::cell_cmd_t   cell_cmd
);
  import pat_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [CW-1:0] LAST_STEP = CW'(DEPTH - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DISP  = 2'd1;
  localparam logic [1:0] S_SRCH  = 2'd2;
  localparam logic [1:0] S_ALIGN = 2'd3;

  logic [1:0]         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      step, step_next;
  logic signed [31:0] key, key_next;

  logic               load;
  logic [2:0]         ld_status;
  logic [5:0]         ld_index;
  logic signed [31:0] ld_data;
  logic               ld_last;

  logic               out_free;
  logic               accept;
  logic [6:0]         count7;
  logic               at_end;
  logic               is_last;
  logic               hit;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = (state != S_IDLE) || !out_free;
  assign accept    = cmd_valid && !cmd_stall;
  assign count7    = 7'(count);
  assign at_end    = (step == LAST_STEP);
  assign is_last   = (step == count - CW'(1));
  assign hit       = (head == key);

  // Command decode and row sequencing. Display and search rotate the whole
  // row once, reading the first cell, so the order is restored at the end.
  always_comb begin
    state_next          = state;
    count_next          = count;
    step_next           = step;
    key_next            = key;
    load                = 1'b0;
    ld_status           = ST_ELEMENT;
    ld_index            = '0;
    ld_data             = '0;
    ld_last             = 1'b1;
    cell_cmd.shift_up   = 1'b0;
    cell_cmd.shift_down = 1'b0;
    cell_cmd.pos        = cmd.position;
    cell_cmd.value      = cmd.value;
    case (state)
      S_IDLE: begin
        if (accept) begin
          step_next = '0;
          key_next  = cmd.value;
          case (cmd.operation)
            OP_DISPLAY: begin
              if (count == '0) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                state_next = S_DISP;
              end
            end
            OP_SEARCH: begin
              if (count == '0) begin
                load      = 1'b1;
                ld_status = ST_NOTFOUND;
              end else begin
                state_next = S_SRCH;
              end
            end
            OP_INSERT: begin
              load = 1'b1;
              if (cmd.position > count7) begin
                ld_status = ST_INVALID;
              end else if (count == DEPTH_C) begin
                ld_status = ST_FULL;
              end else begin
                ld_status         = ST_INSERTED;
                cell_cmd.shift_up = 1'b1;
                count_next        = count + CW'(1);
              end
            end
            OP_DELETE: begin
              load = 1'b1;
              if (cmd.position >= count7) begin
                ld_status = ST_INVALID;
              end else begin
                ld_status           = ST_DELETED;
                cell_cmd.shift_down = 1'b1;
                count_next          = count - CW'(1);
              end
            end
            default: begin
              load      = 1'b1;
              ld_status = ST_INVALID;
            end
          endcase
        end
      end
      S_DISP: begin
        if (out_free) begin
          load                = 1'b1;
          ld_status           = ST_ELEMENT;
          ld_index            = 6'(step);
          ld_data             = head;
          ld_last             = is_last;
          cell_cmd.shift_down = 1'b1;
          cell_cmd.pos        = '0;
          step_next           = step + CW'(1);
          if (at_end) begin
            state_next = S_IDLE;
          end else if (is_last) begin
            state_next = S_ALIGN;
          end
        end
      end
      S_SRCH: begin
        cell_cmd.shift_down = 1'b1;
        cell_cmd.pos        = '0;
        step_next           = step + CW'(1);
        if (hit || is_last) begin
          load       = 1'b1;
          ld_status  = hit ? ST_FOUND : ST_NOTFOUND;
          ld_index   = hit ? 6'(step) : 6'd0;
          state_next = at_end ? S_IDLE : S_ALIGN;
        end
      end
      S_ALIGN: begin
        cell_cmd.shift_down = 1'b1;
        cell_cmd.pos        = '0;
        step_next           = step + CW'(1);
        if (at_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Search key and response payload.
  always_ff @(posedge clk) begin
    key <= key_next;
    if (load) begin
      rsp.status      <= ld_status;
      rsp.index       <= ld_index;
      rsp.data        <= ld_data;
      rsp.entry_count <= 7'(count_next);
      rsp.last        <= ld_last;
    end
  end

endmodule

// ===== src/positional_array_table_unit.sv =====
// ----------------------------------------------------------------------------
// positional_array_table_unit
// Dense table of signed 32-bit entries kept in a row of shifting cells, with
// display, search, insert at a position and delete at a position.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   command   cmd_valid/cmd_stall  cmd (operation, position, value)
//   response  rsp_valid/rsp_stall  rsp (status, index, data, entry_count, last)
//
// Insert and delete shift the row as they are accepted and answer in one transfer.
// Display and search rotate the whole row through cell zero after the
// accepting cycle, and the unit takes no new command until the rotation ends
// (display also waits on each stalled response transfer).
// Reset clears the entry count; cell contents are left as they are.
// A new command is taken only when the sequencer is idle and the response
// register is empty or being drained.
module positional_array_table_unit #(
  parameter int DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  pat_pkg::cmd_t  cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pat_pkg::rsp_t  rsp
);
  import pat_pkg::*;

  cell_cmd_t          cell_cmd;
  logic signed [31:0] cells [DEPTH];

  // Sequencer.
  pat_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .head      (cells[0]),
    .cell_cmd  (cell_cmd)
  );

  // Row of cells; the last cell wraps to the first for rotation.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pat_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .cell_cmd (cell_cmd),
      .left     ((i == 0) ? cells[0] : cells[(i + DEPTH - 1) % DEPTH]),
      .right    (cells[(i + 1) % DEPTH]),
      .data     (cells[i])
    );
  end

endmodule

// ===== tb/sv/positional_array_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_table_checker
// Watches both channels of the positional array table unit. It keeps its own
// copy of the table and count, works out the responses of every accepted
// command, and matches each accepted response against the oldest one due.
// ----------------------------------------------------------------------------
module positional_array_table_checker #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_stall,
  input  pat_pkg::cmd_t cmd,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  pat_pkg::rsp_t rsp,
  output int            outstanding,
  output int            errors
);
  import pat_pkg::*;

  // Shadow table and the responses still owed by the unit.
  logic signed [31:0] table_mem [0:DEPTH-1];
  int                 stored;
  rsp_t               due_rsp [$];
  int                 fail_count = 0;
  int                 due_count  = 0;

  assign outstanding = due_count;
  assign errors      = fail_count;

  // Queue a single closing response that carries a status, an index and the entry count.
  task automatic owe_status(input logic [2:0] status, input int idx);
    rsp_t r;
    r             = '0;
    r.status      = status;
    r.index       = 6'(idx);
    r.entry_count = 7'(stored);
    r.last        = 1'b1;
    due_rsp.push_back(r);
  endtask

  // Apply one command to the shadow table and queue what it should return.
  task automatic apply_command(input cmd_t c);
    rsp_t r;
    int   pos;
    int   hit;
    int   i;
    pos = c.position;
    case (c.operation)
      OP_DISPLAY: begin
        if (stored == 0) begin
          owe_status(ST_EMPTY, 0);
        end else begin
          for (i = 0; i < stored; i++) begin
            r             = '0;
            r.status      = ST_ELEMENT;
            r.index       = 6'(i);
            r.data        = table_mem[i];
            r.entry_count = 7'(stored);
            r.last        = (i == stored - 1);
            due_rsp.push_back(r);
          end
        end
      end
      OP_SEARCH: begin
        hit = -1;
        for (i = 0; i < stored; i++) begin
          if (hit < 0 && table_mem[i] == c.value) hit = i;
        end
        if (hit < 0) owe_status(ST_NOTFOUND, 0);
        else owe_status(ST_FOUND, hit);
      end
      OP_INSERT: begin
        // The position is judged before the table is judged full.
        if (pos > stored) begin
          owe_status(ST_INVALID, 0);
        end else if (stored >= DEPTH) begin
          owe_status(ST_FULL, 0);
        end else begin
          for (i = stored; i > pos; i--) table_mem[i] = table_mem[i-1];
          table_mem[pos] = c.value;
          stored++;
          owe_status(ST_INSERTED, 0);
        end
      end
      default: begin
        if (pos >= stored) begin
          owe_status(ST_INVALID, 0);
        end else begin
          for (i = pos; i + 1 < stored; i++) table_mem[i] = table_mem[i+1];
          stored--;
          owe_status(ST_DELETED, 0);
        end
      end
    endcase
  endtask

  // Responses are checked before the command of the same edge is applied,
  // since a command can never be answered on the edge that accepts it.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      stored = 0;
      due_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: response transfer with nothing due: status %0d index %0d",
                     $realtime, rsp.status, rsp.index);
        end else begin
          want = due_rsp.pop_front();
          if (rsp.status !== want.status || rsp.index !== want.index ||
              rsp.data !== want.data || rsp.entry_count !== want.entry_count ||
              rsp.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch (expected/actual): status %0d/%0d index %0d/%0d",
                       $realtime, want.status, rsp.status, want.index, rsp.index);
              $display("  data %0d/%0d entry_count %0d/%0d last %0b/%0b",
                       want.data, rsp.data, want.entry_count, rsp.entry_count,
                       want.last, rsp.last);
            end
          end
        end
      end
      if (cmd_valid && !cmd_stall) apply_command(cmd);
    end
    due_count = due_rsp.size();
  end

endmodule

// ===== tb/sv/positional_array_table_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_table_unit_tb
// Drives commands into the positional array table unit: a directed opening
// over the corner cases, then random traffic that repeatedly fills the table
// to its limit and drains it, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module positional_array_table_unit_tb;
  import pat_pkg::*;

  localparam int DEPTH      = 64;
  localparam int PHASE_LEN  = 120;
  localparam int HOLD_LEN   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int   outstanding;
  int   errors;

  // Traffic shaping knobs, set by the stimulus process.
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_go   = 1'b0;
  logic hold_on   = 1'b0;

  // Entry count as the commands sent so far leave it, used to aim positions.
  int   fill_level = 0;
  logic growing    = 1'b1;

  always #6 clk = ~clk;

  positional_array_table_unit #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  positional_array_table_checker #(.DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .outstanding (outstanding),
    .errors      (errors)
  );

  // Receiver stall: random, or forced high during a long hold-off.
  always @(negedge clk) begin
    rsp_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
  end

  // Long hold-off on the response side, counted in cycles.
  initial begin
    wait (hold_go);
    @(negedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_LEN) @(negedge clk);
    hold_on <= 1'b0;
  end

  // Overall time limit.
  initial begin
    #36_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Follow the entry count the unit should reach after each command.
  function automatic void track_fill(input cmd_t c);
    if (c.operation == OP_INSERT && c.position <= fill_level && fill_level < DEPTH)
      fill_level++;
    else if (c.operation == OP_DELETE && c.position < fill_level)
      fill_level--;
  endfunction

  // Offer one command, with random idle cycles ahead of it, until transferred.
  task automatic send_command(input cmd_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    track_fill(c);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [6:0] pos,
                             input logic signed [31:0] val);
    cmd_t c;
    c.operation = op;
    c.position  = pos;
    c.value     = val;
    send_command(c);
  endtask

  // Stop offering and wait until every owed response has been transferred.
  task automatic drain_all();
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Values drawn often from a small pool so that searches hit repeats.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh0;
      3:       return -32'sd1;
      4, 5:    return 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // Random command; the mix swings between filling and draining the table.
  task automatic build_command(output cmd_t c);
    int r;
    int ins_pct;
    if (growing && fill_level == DEPTH && $urandom_range(0, 9) == 0)
      growing = 1'b0;
    else if (!growing && fill_level <= $urandom_range(0, 8))
      growing = 1'b1;
    ins_pct = growing ? 70 : 15;
    r = $urandom_range(0, 99);
    c.value = pick_value();
    if (r < 6)                 c.operation = OP_DISPLAY;
    else if (r < 20)           c.operation = OP_SEARCH;
    else if (r < 20 + ins_pct) c.operation = OP_INSERT;
    else                       c.operation = OP_DELETE;
    // Mostly legal positions, some anywhere in the field's range.
    if ($urandom_range(0, 9) == 0 || c.operation == OP_DISPLAY ||
        c.operation == OP_SEARCH)
      c.position = 7'($urandom_range(0, 127));
    else if (c.operation == OP_INSERT)
      c.position = 7'($urandom_range(0, fill_level));
    else
      c.position = 7'(fill_level > 0 ? $urandom_range(0, fill_level - 1) : 0);
  endtask

  initial begin
    cmd_t c;
    int   phase;
    int   n;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening: empty table, boundary positions and extreme values.
    send_fields(OP_DISPLAY, 7'd0,   32'sd0);
    send_fields(OP_SEARCH,  7'd0,   32'sd0);
    send_fields(OP_DELETE,  7'd0,   32'sd0);
    send_fields(OP_INSERT,  7'd1,   32'sd9);
    send_fields(OP_INSERT,  7'd0,   32'sh7FFF_FFFF);
    send_fields(OP_INSERT,  7'd0,   32'sh8000_0000);
    send_fields(OP_INSERT,  7'd2,   32'sd0);
    send_fields(OP_INSERT,  7'd1,   -32'sd1);
    send_fields(OP_INSERT,  7'd4,   -32'sd1);
    send_fields(OP_INSERT,  7'd127, 32'sd5);
    send_fields(OP_DISPLAY, 7'd0,   32'sd0);
    send_fields(OP_SEARCH,  7'd0,   -32'sd1);
    send_fields(OP_SEARCH,  7'd0,   32'sh8000_0000);
    send_fields(OP_SEARCH,  7'd0,   32'sd0);
    send_fields(OP_SEARCH,  7'd0,   32'sd12345);
    send_fields(OP_DELETE,  7'd5,   32'sd0);
    send_fields(OP_DELETE,  7'd127, 32'sd0);
    send_fields(OP_DELETE,  7'd4,   32'sd0);
    send_fields(OP_DELETE,  7'd0,   32'sd0);
    send_fields(OP_DELETE,  7'd1,   32'sd0);
    send_fields(OP_DISPLAY, 7'd127, -32'sd1);
    send_fields(OP_SEARCH,  7'd127, 32'sd0);
    drain_all();

    // Random traffic under four idle and stall patterns.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  hold_go = 1'b1; end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      for (n = 0; n < PHASE_LEN; n++) begin
        build_command(c);
        send_command(c);
      end
      if (phase == 1) drain_all();
    end

    // Wind down and give the verdict.
    cmd_valid <= 1'b0;
    stall_pct = 0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4 * DEPTH) @(negedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
